// ----- rtl/ubs_pkg.sv -----
// Shared types and constants for the undoable byte store.
// Holds operation and status codes, journal entry types and FSM states.
// No dependencies.
package ubs_pkg;

  localparam int unsigned STORE_DEPTH_DEF   = 256;
  localparam int unsigned JOURNAL_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_UNDO  = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] old;
  } jrnl_entry_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    jrnl_entry_t entry;
  } jrnl_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } jrnl_stat_t;

endpackage

// ----- rtl/ubs_journal.sv -----
// Undo journal: a stack of (position, old byte) entries in a synchronous memory.
// Keeps the entry count and registers the top entry when rd_en_i is high.
// Depends on ubs_pkg.
module ubs_journal import ubs_pkg::*; #(
  parameter int unsigned JOURNAL_DEPTH = JOURNAL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  jrnl_req_t   req_i,
  output jrnl_stat_t  stat_o,
  output jrnl_entry_t entry_o
);

  localparam int unsigned CW  = $clog2(JOURNAL_DEPTH + 1);
  localparam int unsigned JAW = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;

  jrnl_entry_t    mem_q [JOURNAL_DEPTH];
  jrnl_entry_t    entry_q;
  logic [CW-1:0]  count_q, count_d;
  logic [JAW-1:0] top_idx, push_idx;

  assign top_idx  = JAW'(count_q - CW'(1));
  assign push_idx = JAW'(count_q);

  always_comb begin
    count_d = count_q;
    if (req_i.push) begin
      count_d = count_q + CW'(1);
    end else if (req_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Read the top entry at transfer; the push lands in a later cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[push_idx] <= req_i.entry;
    end
    if (rd_en_i) begin
      entry_q <= mem_q[top_idx];
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(JOURNAL_DEPTH));
  assign entry_o      = entry_q;

endmodule

// ----- rtl/undoable_byte_store.sv -----
// Undoable byte store: a byte memory with an undo journal stack.
//
// Usage: drive operation_i, position_i and value_i with start_i high; the
// item transfers at the rising edge where start_i is high and busy_o low.
// Operations are read, write with journal, undo, and load without journal.
// At transfer the store entry and the journal top are read from their
// synchronous memories. The following cycle (busy_o high) decides the
// result and writes back the store and the journal. The result is registered
// from that cycle and appears on data_o, where_o and status_o with done_o
// high for exactly one cycle. The receiver cannot stall it. An item passes
// through a memory read at transfer and a write-back in the execute cycle,
// both on the single store port. A new item may transfer in the cycle its
// predecessor's result is shown.
// Reset empties the journal and clears the control state. The store
// contents are undefined until loaded or written; no clearing pass runs.
// Positions wrap modulo STORE_DEPTH.
// Depends on ubs_pkg and ubs_journal.
module undoable_byte_store import ubs_pkg::*; #(
  parameter int unsigned STORE_DEPTH   = STORE_DEPTH_DEF,
  parameter int unsigned JOURNAL_DEPTH = JOURNAL_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] position_i,
  input  logic [7:0] value_i,
  output logic       done_o,
  output logic [7:0] data_o,
  output logic [7:0] where_o,
  output logic [1:0] status_o
);

  localparam int unsigned SAW = $clog2(STORE_DEPTH);

  state_e      state_q, state_d;
  logic        accept;
  logic [7:0]  fold_tbl [256];
  logic [7:0]  pos_fold;

  op_e         op_q;
  logic [7:0]  pos_q, val_q;
  logic [7:0]  store_q [STORE_DEPTH];
  logic [7:0]  cur_q;

  logic        st_we;
  logic [7:0]  st_waddr, st_wdata;

  jrnl_req_t   jreq;
  jrnl_stat_t  jstat;
  jrnl_entry_t jtop;

  logic        done_q, done_d;
  logic [7:0]  data_q, data_d, where_q, where_d;
  status_e     status_q, status_d;

  // Constant wrap table for positions beyond the store.
  for (genvar g = 0; g < 256; g++) begin : g_fold
    assign fold_tbl[g] = 8'(g % STORE_DEPTH);
  end

  assign pos_fold = fold_tbl[position_i];
  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q == S_EXEC);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      pos_q <= pos_fold;
      val_q <= value_i;
    end
  end

  // Store memory: read at transfer, write back in the execute cycle.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_q[SAW'(st_waddr)] <= st_wdata;
    end else if (accept) begin
      cur_q <= store_q[SAW'(pos_fold)];
    end
  end

  ubs_journal #(
    .JOURNAL_DEPTH(JOURNAL_DEPTH)
  ) u_journal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_en_i(accept),
    .req_i  (jreq),
    .stat_o (jstat),
    .entry_o(jtop)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      data_q   <= data_d;
      where_q  <= where_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    data_d      = cur_q;
    where_d     = pos_q;
    status_d    = ST_OK;
    st_we       = 1'b0;
    st_waddr    = pos_q;
    st_wdata    = val_q;
    jreq.push   = 1'b0;
    jreq.pop    = 1'b0;
    jreq.entry  = '{pos: pos_q, old: cur_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        unique case (op_q)
          OP_READ: begin
          end
          OP_WRITE: begin
            if (jstat.full) begin
              status_d = ST_FULL;
            end else begin
              jreq.push = 1'b1;
              st_we     = 1'b1;
            end
          end
          OP_UNDO: begin
            if (jstat.empty) begin
              data_d   = '0;
              where_d  = '0;
              status_d = ST_EMPTY;
            end else begin
              // Restore the old byte from the journal top.
              jreq.pop = 1'b1;
              st_we    = 1'b1;
              st_waddr = jtop.pos;
              st_wdata = jtop.old;
              data_d   = jtop.old;
              where_d  = jtop.pos;
            end
          end
          OP_LOAD: begin
            st_we = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o   = done_q;
  assign data_o   = data_q;
  assign where_o  = where_q;
  assign status_o = status_q;

  a_one_exec_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("execute state held for more than one cycle");

  a_done_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |=> done_o)
    else $error("result strobe missing after execute cycle");

  a_done_only_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without an execute cycle");

  a_journal_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(jstat.empty && jstat.full))
    else $error("journal reported empty and full together");

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (jreq.push || jreq.pop || st_we) |-> busy_o)
    else $error("memory update outside the execute cycle");

endmodule
